// ----- rtl/jse_pkg.sv -----
`timescale 1ns / 1ps

package jse_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 3;

  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_PAIR = 2'd1;
  localparam logic [1:0] KIND_UESC = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_TAB   = 8'h09;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [15:0] BAD_SEQ_VAL = 16'h001A;

  localparam logic [15:0][7:0] HEX_DIGITS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             rest_idle;
    logic [1:0]       consume;
    logic [BYTE_W-1:0] data;
  } tok_t;

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

// ----- rtl/jse_tok_dec.sv -----
`timescale 1ns / 1ps

module jse_tok_dec (
  input  logic [jse_pkg::BYTE_W-1:0] q0,
  input  logic [jse_pkg::BYTE_W-1:0] q1,
  input  logic [jse_pkg::BYTE_W-1:0] q2,
  input  logic [1:0]                 qlen,
  input  logic                       str_end,
  input  logic [jse_pkg::IDX_W-1:0]  idx,
  output jse_pkg::tok_t              tok
);
  import jse_pkg::*;

  logic [1:0]        kind;
  logic [7:0]        ch;
  logic [15:0]       val;
  logic [2:0]        nbytes;
  logic [1:0]        rem;
  logic [7:0]        r0;
  logic              emits;
  logic [1:0]        consume;
  logic [BYTE_W-1:0] data;
  logic              rest_idle;

  always_comb begin
    kind = KIND_LIT;
    ch = q0;
    val = BAD_SEQ_VAL;
    emits = 1'b1;
    consume = 2'd1;
    if (qlen == 2'd0) begin
      emits = 1'b0;
    end else if (!q0[7]) begin
      if (q0 == CH_QUOTE || q0 == CH_BSLASH || q0 == CH_SLASH) begin
        kind = KIND_PAIR;
      end else if (q0 >= CH_SPACE) begin
        kind = KIND_LIT;
      end else begin
        kind = KIND_PAIR;
        case (q0)
          CTL_BS:  ch = CH_B;
          CTL_FF:  ch = CH_F;
          CTL_LF:  ch = CH_N;
          CTL_CR:  ch = CH_R;
          CTL_TAB: ch = CH_T;
          default: begin
            kind = KIND_UESC;
            val = {8'h00, q0};
          end
        endcase
      end
    end else if (qlen < 2'd2) begin
      kind = KIND_UESC;
      emits = str_end;
    end else if (!is_cont(q1)) begin
      kind = KIND_UESC;
    end else if (q0[7:5] != 3'b111) begin
      kind = KIND_UESC;
      val = {5'b00000, q0[4:0], q1[5:0]};
      consume = 2'd2;
    end else if (qlen < 2'd3) begin
      kind = KIND_UESC;
      emits = str_end;
    end else if (!is_cont(q2) || q0[7:4] == 4'hF) begin
      kind = KIND_UESC;
    end else begin
      kind = KIND_UESC;
      val = {q0[3:0], q1[5:0], q2[5:0]};
      consume = 2'd3;
    end
  end

  always_comb begin
    case (kind)
      KIND_LIT:  nbytes = 3'd1;
      KIND_PAIR: nbytes = 3'd2;
      default:   nbytes = 3'd6;
    endcase
  end

  always_comb begin
    data = CH_BSLASH;
    case (kind)
      KIND_LIT: data = ch;
      KIND_PAIR: data = (idx == 3'd0) ? CH_BSLASH : ch;
      default: begin
        case (idx)
          3'd0:    data = CH_BSLASH;
          3'd1:    data = CH_U;
          3'd2:    data = HEX_DIGITS[val[15:12]];
          3'd3:    data = HEX_DIGITS[val[11:8]];
          3'd4:    data = HEX_DIGITS[val[7:4]];
          default: data = HEX_DIGITS[val[3:0]];
        endcase
      end
    endcase
  end

  // Whether the bytes left after this token produce nothing until more input arrives.
  always_comb begin
    rem = qlen - consume;
    r0 = (consume == 2'd1) ? q1 : q2;
    if (rem == 2'd0) begin
      rest_idle = 1'b1;
    end else begin
      rest_idle = !str_end && r0[7] &&
                  (rem == 2'd1 || (is_cont(q2) && r0[7:5] == 3'b111));
    end
  end

  assign tok = '{valid:     emits,
                 last:      (idx == nbytes - 3'd1),
                 rest_idle: rest_idle,
                 consume:   consume,
                 data:      data};

endmodule

// ----- rtl/jse_out_reg.sv -----
`timescale 1ns / 1ps

module jse_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [jse_pkg::BYTE_W-1:0] load_data,
  input  logic                       load_last,
  output logic                       space,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [jse_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import jse_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] data_r;
  logic              last_r;

  assign space = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
      last_r <= load_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// ----- rtl/json_string_escaper_top.sv -----
`timescale 1ns / 1ps
// Channel | Direction | tdata         | tlast
// in_     | slave     | [7:0] in_byte | string_end
// out_    | master    | [7:0] out_byte| run_end
//
// A queue of up to three source bytes feeds a token decoder that emits one output byte per cycle
// when the output register has space; plain characters give one byte, short escapes two, \uXXXX six.
// Input is taken while the queue is empty or waiting for UTF-8 lookahead, or as the last byte
// of the final pending token is emitted; the output register takes a beat when empty or being read.
// Reset is synchronous, active low, and empties the queue and the output register.

module json_string_escaper_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import jse_pkg::*;

  logic [BYTE_W-1:0] q_r [3];
  logic [BYTE_W-1:0] q_nxt [3];
  logic [1:0]        len_r, len_nxt;
  logic              end_r, end_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  tok_t              tok;
  logic              space;
  logic              emit;
  logic              pop;
  logic              in_fire;

  jse_tok_dec u_dec (
    .q0      (q_r[0]),
    .q1      (q_r[1]),
    .q2      (q_r[2]),
    .qlen    (len_r),
    .str_end (end_r),
    .idx     (idx_r),
    .tok     (tok)
  );

  assign emit      = tok.valid && space;
  assign pop       = emit && tok.last;
  assign in_tready = !tok.valid || (pop && tok.rest_idle);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    q_nxt = q_r;
    len_nxt = len_r;
    end_nxt = end_r;
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = '0;
      len_nxt = len_r - tok.consume;
      if (tok.consume == 2'd1) begin
        q_nxt[0] = q_r[1];
        q_nxt[1] = q_r[2];
      end else begin
        q_nxt[0] = q_r[2];
      end
    end else if (emit) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (in_fire) begin
      case (len_nxt)
        2'd0:    q_nxt[0] = in_tdata;
        2'd1:    q_nxt[1] = in_tdata;
        default: q_nxt[2] = in_tdata;
      endcase
      len_nxt = len_nxt + 2'd1;
      end_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      end_r <= 1'b0;
      idx_r <= '0;
    end else begin
      len_r <= len_nxt;
      end_r <= end_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  jse_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .load_data  (tok.data),
    .load_last  (tok.last && tok.rest_idle),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
